### rtl/core/ght_pkg.sv
// Shared types and constants for the generation handle table.
// Command and status codes, stream word layout and the slot record format.
// No dependencies.
package ght_pkg;

	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int GEN_W     = 32;
	localparam int PAYLOAD_W = 32;
	localparam int PIN_W     = 16;
	localparam int SIDX_W    = 6;
	localparam int HANDLE_W  = 64;

	// s_tdata: handle, slot_index, payload, zero pad to whole bytes
	localparam int IN_DATA_W  = 104;
	// m_tdata: handle_out, slot_out, payload_out, release_valid, release_payload, pad
	localparam int OUT_DATA_W = 136;

	localparam logic [GEN_W-1:0] GEN_MAX = 32'hFFFF_FFFF;
	localparam logic [PIN_W-1:0] PIN_MAX = 16'hFFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN  = 2'd0,
		CMD_PIN   = 2'd1,
		CMD_UNPIN = 2'd2,
		CMD_CLOSE = 2'd3
	} ght_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DEFERRED = 3'd1,
		ST_INVALID  = 3'd2,
		ST_FULL     = 3'd3,
		ST_PIN_SAT  = 3'd4
	} ght_status_t;

	// One slot as held in the slot RAM
	typedef struct packed {
		logic [GEN_W-1:0]     gen;
		logic [PAYLOAD_W-1:0] payload;
		logic [PIN_W-1:0]     pin_cnt;
		logic [PAYLOAD_W-1:0] dying_payload;
	} ght_entry_t;

endpackage

### rtl/core/ght_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot store of the generation handle table. No dependencies.
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/generation_handle_table.sv
// Generation handle table top level: command stream in, result stream out.
// Depends on ght_pkg and ght_ram.
//
// Usage:
//   The slave stream carries one command per word: s_tuser holds the command
//   code (open, pin, unpin, close), s_tdata the handle, slot index and payload.
//   The master stream returns exactly one result word per command: m_tuser
//   holds the status, m_tdata the new handle, pinned slot and payload, and a
//   payload the host must release (release_valid marks it).
//   Each command first reads the slot RAM through its registered read port,
//   then modifies the slot and writes it back. A new command is taken only
//   once the previous one has left the modify stage.
//   The result is written to an output register as the command leaves the
//   modify stage; s_tready is high again while that word waits to be taken.
//   If m_tready stays low, the next command is read but held in the modify
//   stage until the output register frees, so at most one result waits.
//   The lowest free slot for open comes from a priority encoder over the open
//   and dying bits, which are kept in flip-flops.
//   After reset the slot RAM is cleared, one slot per cycle, from slot 0 up to
//   slot SLOTS-1; s_tready stays low until that pass is done.
module generation_handle_table #(
	parameter int SLOTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [63:0] handle, [69:64] slot_index, [101:70] payload, [103:102] zero
	input  logic [ght_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] cmd
	input  logic [ght_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [63:0] handle_out, [69:64] slot_out, [101:70] payload_out,
	// [102] release_valid, [134:103] release_payload, [135] zero
	output logic [ght_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [2:0] status
	output logic [ght_pkg::STATUS_W-1:0]    m_tuser
);

	import ght_pkg::*;

	localparam int IW = $clog2(SLOTS);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic [IW-1:0] clr_cnt_q;

	logic [SLOTS-1:0] open_q;
	logic [SLOTS-1:0] dying_q;

	// Input unpack
	logic [HANDLE_W-1:0]  in_handle;
	logic [SIDX_W-1:0]    in_sidx;
	logic [PAYLOAD_W-1:0] in_payload;
	ght_cmd_t             in_cmd;

	assign in_handle  = s_tdata[63:0];
	assign in_sidx    = s_tdata[69:64];
	assign in_payload = s_tdata[101:70];
	assign in_cmd     = ght_cmd_t'(s_tuser);

	// Free-slot search: lowest slot neither open nor dying
	logic [SLOTS-1:0] free_vec;
	logic [IW-1:0]    free_idx;
	logic             free_any;

	assign free_vec = ~open_q & ~dying_q;

	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	// Address select for the accepted command
	logic [31:0]   req_idx;
	logic          req_ok;
	logic [IW-1:0] req_addr;
	logic          s_fire;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	always_comb begin
		if (in_cmd == CMD_UNPIN) begin
			req_idx = {{(32 - SIDX_W){1'b0}}, in_sidx};
		end else begin
			req_idx = in_handle[31:0];
		end
		req_ok = (req_idx < 32'(SLOTS));
		if (in_cmd == CMD_OPEN) begin
			req_addr = free_idx;
		end else begin
			req_addr = IW'(req_idx);
		end
	end

	// Stage 1 registers: command held across the RAM read
	ght_cmd_t             cmd_s1;
	logic [GEN_W-1:0]     gen_s1;
	logic [PAYLOAD_W-1:0] payload_s1;
	logic [IW-1:0]        idx_s1;
	logic                 idx_ok_s1;
	logic                 free_any_s1;

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1      <= in_cmd;
			gen_s1      <= in_handle[63:32];
			payload_s1  <= in_payload;
			idx_s1      <= req_addr;
			idx_ok_s1   <= req_ok;
			free_any_s1 <= free_any;
		end
	end

	// Slot RAM
	ght_entry_t rd_entry;
	ght_entry_t wr_entry;
	logic       ram_we;
	logic [IW-1:0] ram_waddr;
	logic [$bits(ght_entry_t)-1:0] ram_wdata;
	logic [$bits(ght_entry_t)-1:0] ram_rdata;

	ght_ram #(
		.WIDTH ($bits(ght_entry_t)),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (s_fire),
		.raddr (req_addr),
		.rdata (ram_rdata)
	);

	assign rd_entry = ght_entry_t'(ram_rdata);

	logic exec_fire;
	logic m_tvalid_q;

	assign exec_fire = (state_q == S_EXEC) && (!m_tvalid_q || m_tready);

	// Modify stage
	logic                 hit;
	logic                 set_open;
	logic                 clr_open;
	logic                 set_dying;
	logic                 clr_dying;
	ght_status_t          res_status;
	logic [HANDLE_W-1:0]  res_handle;
	logic [SIDX_W-1:0]    res_slot;
	logic [PAYLOAD_W-1:0] res_payload;
	logic                 res_rel_valid;
	logic [PAYLOAD_W-1:0] res_rel_payload;
	logic [GEN_W-1:0]     open_gen;

	always_comb begin
		hit       = idx_ok_s1 && open_q[idx_s1] && (rd_entry.gen == gen_s1);
		open_gen  = (rd_entry.gen == '0) ? GEN_W'(1) : rd_entry.gen;
		wr_entry  = rd_entry;
		set_open  = 1'b0;
		clr_open  = 1'b0;
		set_dying = 1'b0;
		clr_dying = 1'b0;
		res_status      = ST_OK;
		res_handle      = '0;
		res_slot        = '0;
		res_payload     = '0;
		res_rel_valid   = 1'b0;
		res_rel_payload = '0;
		unique case (cmd_s1)
			CMD_OPEN: begin
				if (!free_any_s1) begin
					res_status      = ST_FULL;
					res_rel_valid   = 1'b1;
					res_rel_payload = payload_s1;
				end else begin
					wr_entry.gen     = open_gen;
					wr_entry.payload = payload_s1;
					set_open         = 1'b1;
					res_handle       = {open_gen, 32'(idx_s1)};
				end
			end
			CMD_PIN: begin
				if (!hit) begin
					res_status = ST_INVALID;
				end else if (rd_entry.pin_cnt == PIN_MAX) begin
					res_status = ST_PIN_SAT;
				end else begin
					wr_entry.pin_cnt = rd_entry.pin_cnt + PIN_W'(1);
					res_slot         = SIDX_W'(32'(idx_s1));
					res_payload      = rd_entry.payload;
				end
			end
			CMD_UNPIN: begin
				if (!idx_ok_s1 || rd_entry.pin_cnt == '0) begin
					res_status = ST_INVALID;
				end else begin
					wr_entry.pin_cnt = rd_entry.pin_cnt - PIN_W'(1);
					// last pin of a closed slot: hand the deferred payload back
					if (rd_entry.pin_cnt == PIN_W'(1) && dying_q[idx_s1]) begin
						res_rel_valid          = 1'b1;
						res_rel_payload        = rd_entry.dying_payload;
						wr_entry.dying_payload = '0;
						clr_dying              = 1'b1;
					end
				end
			end
			CMD_CLOSE: begin
				if (!hit) begin
					res_status = ST_INVALID;
				end else begin
					clr_open = 1'b1;
					if (rd_entry.pin_cnt != '0) begin
						set_dying              = 1'b1;
						wr_entry.dying_payload = rd_entry.payload;
						res_status             = ST_DEFERRED;
					end else begin
						res_rel_valid   = 1'b1;
						res_rel_payload = rd_entry.payload;
					end
					wr_entry.payload = '0;
					if (rd_entry.gen != GEN_MAX) begin
						wr_entry.gen = rd_entry.gen + GEN_W'(1);
					end
				end
			end
			default: begin
				res_status = ST_INVALID;
			end
		endcase
	end

	// Clear pass writes zeros; otherwise write the slot back after modify
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = exec_fire;
			ram_waddr = idx_s1;
			ram_wdata = wr_entry;
		end
	end

	// Control, flag vectors and output register
	logic [ght_pkg::STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0]  handle_out_q;
	logic [SIDX_W-1:0]    slot_out_q;
	logic [PAYLOAD_W-1:0] payload_out_q;
	logic                 rel_valid_q;
	logic [PAYLOAD_W-1:0] rel_payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_cnt_q  <= '0;
			open_q     <= '0;
			dying_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_cnt_q == IW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (s_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (exec_fire) begin
				if (set_open) begin
					open_q[idx_s1] <= 1'b1;
				end
				if (clr_open) begin
					open_q[idx_s1] <= 1'b0;
				end
				if (set_dying) begin
					dying_q[idx_s1] <= 1'b1;
				end
				if (clr_dying) begin
					dying_q[idx_s1] <= 1'b0;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q      <= res_status;
			handle_out_q  <= res_handle;
			slot_out_q    <= res_slot;
			payload_out_q <= res_payload;
			rel_valid_q   <= res_rel_valid;
			rel_payload_q <= res_rel_payload;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, rel_payload_q, rel_valid_q, payload_out_q, slot_out_q,
		handle_out_q};

endmodule

### bench/ght_checker.sv
`timescale 1ns / 1ps
// Result checker for the generation handle table bench: keeps its own copy of the slot table,
// predicts one result word per accepted command and compares it field by field.
// Depends on ght_pkg.
module ght_checker #(
	parameter int SLOTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ght_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [ght_pkg::CMD_W-1:0]      s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [ght_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [ght_pkg::STATUS_W-1:0]   m_tuser,
	output int                             fail_count,
	output int                             pending
);
	import ght_pkg::*;

	localparam int REPORT_CAP = 40;

	typedef struct packed {
		ght_status_t          status;
		logic [HANDLE_W-1:0]  handle;
		logic [SIDX_W-1:0]    slot;
		logic [PAYLOAD_W-1:0] payload;
		logic                 rel_valid;
		logic [PAYLOAD_W-1:0] rel_payload;
	} outcome_t;

	logic                 is_open   [SLOTS];
	logic [GEN_W-1:0]     gen_of    [SLOTS];
	logic [PAYLOAD_W-1:0] tag_of    [SLOTS];
	logic [PIN_W-1:0]     pins      [SLOTS];
	logic                 dying     [SLOTS];
	logic [PAYLOAD_W-1:0] dying_tag [SLOTS];

	outcome_t expected_q[$];
	outcome_t want;

	// Apply one command to the shadow table and return the word it must produce.
	function automatic outcome_t table_apply(ght_cmd_t c, logic [HANDLE_W-1:0] h,
			logic [SIDX_W-1:0] si, logic [PAYLOAD_W-1:0] p);
		outcome_t r;
		int hit;
		int free_slot;
		int i;
		logic [SIDX_W-1:0] k;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		free_slot = -1;
		k = h[SIDX_W-1:0];
		if (h[31:0] < 32'(SLOTS) && is_open[k] && gen_of[k] == h[63:32])
			hit = int'(k);
		case (c)
			CMD_OPEN: begin
				for (i = 0; i < SLOTS; i++)
					if (free_slot < 0 && !is_open[i] && !dying[i])
						free_slot = i;
				if (free_slot < 0) begin
					r.status = ST_FULL;
					r.rel_valid = 1'b1;
					r.rel_payload = p;
				end else begin
					// never hand out generation zero
					if (gen_of[free_slot] == '0)
						gen_of[free_slot] = 1;
					tag_of[free_slot] = p;
					is_open[free_slot] = 1'b1;
					r.handle = {gen_of[free_slot], 32'(free_slot)};
				end
			end
			CMD_PIN: begin
				if (hit < 0) begin
					r.status = ST_INVALID;
				end else if (pins[hit] == PIN_MAX) begin
					r.status = ST_PIN_SAT;
				end else begin
					pins[hit] = pins[hit] + 1'b1;
					r.slot = k;
					r.payload = tag_of[hit];
				end
			end
			CMD_UNPIN: begin
				if (32'(si) >= 32'(SLOTS) || pins[si] == '0) begin
					r.status = ST_INVALID;
				end else begin
					pins[si] = pins[si] - 1'b1;
					if (pins[si] == '0 && dying[si]) begin
						r.rel_valid = 1'b1;
						r.rel_payload = dying_tag[si];
						dying[si] = 1'b0;
						dying_tag[si] = '0;
					end
				end
			end
			CMD_CLOSE: begin
				if (hit < 0) begin
					r.status = ST_INVALID;
				end else begin
					is_open[hit] = 1'b0;
					// defer the release while pins are held
					if (pins[hit] != '0) begin
						dying[hit] = 1'b1;
						dying_tag[hit] = tag_of[hit];
						r.status = ST_DEFERRED;
					end else begin
						r.rel_valid = 1'b1;
						r.rel_payload = tag_of[hit];
					end
					tag_of[hit] = '0;
					if (gen_of[hit] != GEN_MAX)
						gen_of[hit] = gen_of[hit] + 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want_v, got_v);
		if (want_v !== got_v) begin
			fail_count++;
			if (fail_count <= REPORT_CAP)
				$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				is_open[i] = 1'b0;
				gen_of[i] = '0;
				tag_of[i] = '0;
				pins[i] = '0;
				dying[i] = 1'b0;
				dying_tag[i] = '0;
			end
			expected_q.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_q.push_back(table_apply(ght_cmd_t'(s_tuser), s_tdata[63:0],
					s_tdata[69:64], s_tdata[101:70]));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					$error("result word with no command waiting");
				end else begin
					want = expected_q.pop_front();
					check_field("status", 64'(want.status), 64'(m_tuser));
					check_field("handle_out", want.handle, m_tdata[63:0]);
					check_field("slot_out", 64'(want.slot), 64'(m_tdata[69:64]));
					check_field("payload_out", 64'(want.payload), 64'(m_tdata[101:70]));
					check_field("release_valid", 64'(want.rel_valid), 64'(m_tdata[102]));
					check_field("release_payload", 64'(want.rel_payload),
						64'(m_tdata[134:103]));
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the generation handle table bench: clock, reset, command traffic and the verdict.
// Depends on ght_pkg, generation_handle_table and ght_checker.
module testbench;
	import ght_pkg::*;

	localparam int SLOTS       = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int PIN_RUN     = 8;
	// about 470 words under the worst stall mix, plus one long hold
	localparam int CYCLE_LIMIT = 50_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int sent_count;
	int recv_count;
	int cycle_count;
	int hold_left = 0;
	logic hold_go;
	logic hold_used = 1'b0;

	logic [HANDLE_W-1:0] live_handles[$];
	logic [SIDX_W-1:0]   pinned_slots[$];

	always #5 clk = ~clk;

	generation_handle_table #(.SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ght_checker #(.SLOTS(SLOTS)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Collect handles from successful opens for later pins and closes.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			recv_count++;
			if (m_tdata[63:0] != '0)
				live_handles.push_back(m_tdata[63:0]);
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_go && !hold_used) begin
			hold_left = HOLD_CYCLES;
			hold_used = 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [HANDLE_W-1:0] mk_handle(logic [31:0] g, logic [31:0] idx);
		return {g, idx};
	endfunction

	// Offer one word at the falling edge and hold it until taken.
	task automatic send_cmd(ght_cmd_t c, logic [HANDLE_W-1:0] h, logic [SIDX_W-1:0] si,
			logic [PAYLOAD_W-1:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {2'b00, p, si, h};
		do
			@(posedge clk);
		while (!s_tready);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (recv_count != sent_count)
			@(negedge clk);
	endtask

	// Mostly a known handle; now and then a forged or random one.
	task automatic pick_handle(output logic [HANDLE_W-1:0] h, input bit retire);
		int k;
		if (live_handles.size() == 0 || $urandom_range(6) == 0) begin
			case ($urandom_range(2))
				0: h = {$urandom, $urandom};
				1: h = mk_handle(32'($urandom_range(3)), 32'($urandom_range(63)));
				default: h = mk_handle($urandom, 32'($urandom_range(63)));
			endcase
		end else begin
			k = $urandom_range(live_handles.size() - 1);
			h = live_handles[k];
			if (retire && $urandom_range(9) != 0)
				live_handles.delete(k);
		end
	endtask

	task automatic random_cmd(int open_pct);
		int r;
		int k;
		logic [HANDLE_W-1:0] h;
		logic [SIDX_W-1:0] si;
		r = $urandom_range(99);
		if (r < open_pct) begin
			send_cmd(CMD_OPEN, {$urandom, $urandom}, 6'($urandom), $urandom);
		end else if (r < open_pct + 30) begin
			pick_handle(h, 1'b0);
			pinned_slots.push_back(h[SIDX_W-1:0]);
			send_cmd(CMD_PIN, h, 6'($urandom), $urandom);
		end else if (r < open_pct + 45) begin
			if (pinned_slots.size() > 0 && $urandom_range(9) != 0) begin
				k = $urandom_range(pinned_slots.size() - 1);
				si = pinned_slots[k];
				pinned_slots.delete(k);
			end else begin
				si = 6'($urandom);
			end
			send_cmd(CMD_UNPIN, {$urandom, $urandom}, si, $urandom);
		end else begin
			pick_handle(h, 1'b1);
			send_cmd(CMD_CLOSE, h, 6'($urandom), $urandom);
		end
	endtask

	initial begin
		logic [HANDLE_W-1:0] sat_h;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_OPEN;
		hold_go = 1'b0;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, generation zero, skip of dying slots, stale and bad handles
		send_cmd(CMD_PIN, mk_handle(1, 0), '0, '0);
		send_cmd(CMD_UNPIN, '0, 6'd0, '0);
		send_cmd(CMD_CLOSE, '0, '0, '0);
		send_cmd(CMD_OPEN, '0, '0, 32'h0000_0000);
		send_cmd(CMD_OPEN, '0, '0, 32'hFFFF_FFFF);
		send_cmd(CMD_PIN, mk_handle(1, 0), '0, '0);
		send_cmd(CMD_PIN, mk_handle(1, 1), '0, '0);
		send_cmd(CMD_PIN, mk_handle(2, 0), '0, '0);
		send_cmd(CMD_PIN, mk_handle(1, 64), '0, '0);
		send_cmd(CMD_PIN, mk_handle(1, 32'h8000_0000), '0, '0);
		send_cmd(CMD_CLOSE, mk_handle(1, 1), '0, '0);
		send_cmd(CMD_OPEN, '0, '0, 32'hA5A5_A5A5);
		send_cmd(CMD_UNPIN, '0, 6'd1, '0);
		send_cmd(CMD_UNPIN, '0, 6'd1, '0);
		send_cmd(CMD_UNPIN, '0, 6'd0, '0);
		send_cmd(CMD_CLOSE, mk_handle(1, 0), '0, '0);
		send_cmd(CMD_CLOSE, mk_handle(1, 0), '0, '0);
		send_cmd(CMD_OPEN, '0, '0, 32'h1234_5678);
		send_cmd(CMD_CLOSE, '1, '0, '0);
		send_cmd(CMD_UNPIN, '0, 6'd63, '0);
		s_tvalid <= 1'b0;
		wait_drained();

		// pin one slot several times, close it pinned, then unpin it all the way down
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_cmd(CMD_OPEN, '0, '0, 32'h5A5A_0001);
		s_tvalid <= 1'b0;
		wait_drained();
		sat_h = live_handles[$];
		repeat (PIN_RUN) send_cmd(CMD_PIN, sat_h, '0, '0);
		send_cmd(CMD_CLOSE, sat_h, '0, '0);
		send_cmd(CMD_PIN, sat_h, '0, '0);
		send_cmd(CMD_OPEN, '0, '0, 32'h5A5A_0002);
		repeat (PIN_RUN) send_cmd(CMD_UNPIN, '0, sat_h[SIDX_W-1:0], '0);
		send_cmd(CMD_UNPIN, '0, sat_h[SIDX_W-1:0], '0);

		// random traffic: open-heavy first half, close-heavy second half, per stall pattern
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 66 : 0;
			recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 36 : 0;
			if (mode == 2) begin
				// hold the result side while opens overrun the table
				hold_go = 1'b1;
				repeat (70) send_cmd(CMD_OPEN, {$urandom, $urandom}, 6'($urandom), $urandom);
				hold_go = 1'b0;
			end
			for (int n = 0; n < 120; n++)
				random_cmd((n < 60) ? 50 : 20);
		end
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (10) @(negedge clk);
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		$display("Ran %0d commands: directed handle cases, a pinned close with deferred release,",
			sent_count);
		$display("a table overrun under a long result stall, and random traffic with three stall mixes.");
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
